// ===== hw/rtl/mne_pkg.sv =====
// ============================================================================
// mne_pkg
// Shared widths, constants and types of the MCRA noise estimator.
// ============================================================================
package mne_pkg;

    localparam int WINDOW_LENGTH = 512;
    localparam int NUM_BINS      = WINDOW_LENGTH / 2 + 1;

    localparam int MAG_W   = 24;
    localparam int BIN_W   = 9;
    localparam int FRAME_W = 20;
    localparam int PROB_W  = 15;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    localparam int FRAC_BITS   = 14;
    localparam int ONE_Q14     = 16384;
    localparam int SPEECH_STEP = ONE_Q14 / 2 + ONE_Q14 / 4;

    localparam int FAST_FRAMES  = 10;
    localparam int REARM_PERIOD = 50;

    // (frame + 1) mod 50 == 0  <=>  even and half divisible by 25
    localparam int HALF_PERIOD = REARM_PERIOD / 2;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + HALF_PERIOD - 1) / HALF_PERIOD;
    localparam int RECIP_W     = 22;
    localparam int QUOT_W      = 16;

    localparam int MIX_W  = MAG_W + 1;
    localparam int DIFF_W = MAG_W + 2;
    localparam int PROD_W = DIFF_W + PROB_W + 1;

    typedef struct packed {
        logic [MAG_W-1:0]  level;
        logic [MAG_W-1:0]  win_min;
        logic [MAG_W-1:0]  run_min;
        logic [PROB_W-1:0] presence;
        logic [MAG_W-1:0]  noise;
    } bin_state_t;

    typedef struct packed {
        logic [MAG_W-1:0]  level;
        logic [MAG_W-1:0]  win_min;
        logic [MAG_W-1:0]  run_min;
        logic [PROB_W-1:0] presence;
        logic [MIX_W-1:0]  mix;
        logic [DIFF_W-1:0] diff;
    } bin_update_t;

endpackage

// ===== hw/rtl/mne_bin_update.sv =====
// ============================================================================
// mne_bin_update
// Smoothing, minimum tracking, presence decision and noise mix terms of one
// bin, from its stored state and the new magnitude.
// ============================================================================
module mne_bin_update (
    input  mne_pkg::bin_state_t      state_i,
    input  logic [mne_pkg::MAG_W-1:0] magnitude,
    input  logic                      rearm,
    output mne_pkg::bin_update_t      upd_o
);

    logic [mne_pkg::MAG_W+1:0]  level_sum;
    logic [mne_pkg::MAG_W-1:0]  level_new;
    logic [mne_pkg::MAG_W-1:0]  win_min_a;
    logic [mne_pkg::MAG_W-1:0]  run_min_a;
    logic [mne_pkg::MAG_W-1:0]  win_min_b;
    logic [mne_pkg::MAG_W-1:0]  run_min_b;
    logic [mne_pkg::MAG_W+1:0]  thr;
    logic                       speech;
    logic [mne_pkg::PROB_W-1:0] prob_sum;
    logic [mne_pkg::PROB_W-1:0] prob_new;
    logic [mne_pkg::MIX_W-1:0]  mix;

    always_comb begin
        level_sum = (mne_pkg::MAG_W+2)'(state_i.level >> 1)
                  + (mne_pkg::MAG_W+2)'(state_i.level >> 2)
                  + (mne_pkg::MAG_W+2)'(state_i.level >> 4)
                  + (mne_pkg::MAG_W+2)'(magnitude >> 3)
                  + (mne_pkg::MAG_W+2)'(magnitude >> 4);
        level_new = level_sum[mne_pkg::MAG_W-1:0];

        if (rearm) begin
            win_min_a = (state_i.run_min < state_i.level) ? state_i.run_min : state_i.level;
            run_min_a = state_i.level;
        end else begin
            win_min_a = state_i.win_min;
            run_min_a = state_i.run_min;
        end
        win_min_b = (level_new < win_min_a) ? level_new : win_min_a;
        run_min_b = (level_new < run_min_a) ? level_new : run_min_a;

        thr    = {2'b00, win_min_b >> 2} + {1'b0, win_min_b, 1'b0};
        speech = {2'b00, level_new} > thr;

        prob_sum = (state_i.presence >> 2)
                 + (speech ? mne_pkg::PROB_W'(mne_pkg::SPEECH_STEP) : '0);
        prob_new = (prob_sum > mne_pkg::PROB_W'(mne_pkg::ONE_Q14))
                 ? mne_pkg::PROB_W'(mne_pkg::ONE_Q14) : prob_sum;

        mix = mne_pkg::MIX_W'(state_i.noise >> 1)
            + mne_pkg::MIX_W'(state_i.noise >> 2)
            + mne_pkg::MIX_W'(state_i.noise >> 3)
            + mne_pkg::MIX_W'(state_i.noise >> 4)
            + mne_pkg::MIX_W'(magnitude >> 4);

        upd_o.level    = level_new;
        upd_o.win_min  = win_min_b;
        upd_o.run_min  = run_min_b;
        upd_o.presence = prob_new;
        upd_o.mix      = mix;
        upd_o.diff     = {2'b00, state_i.noise} - {1'b0, mix};
    end

endmodule

// ===== hw/rtl/mcra_noise_estimator_unit.sv =====
// ============================================================================
// mcra_noise_estimator_unit
// Per-bin MCRA noise tracker over a stream of spectral magnitudes.
// ============================================================================
// One item per cycle enters while the output is not stalled and no in-range
// bin repeats within four consecutive items; results leave in order through an
// output register. The per-bin state sits in one memory of 257 words read at
// acceptance and written back from the last stage, so an item whose bin is
// still in flight waits until the earlier update has been written. Bins
// above 256 pass through with zero noise and presence and touch no state.
// After reset every bin reads as zero until it is first written; no clearing
// pass is needed.
module mcra_noise_estimator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // magnitude[23:0], bin[32:24], frame_number[52:33], zero fill
    input  logic [mne_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // noise_estimate[23:0], presence_prob[38:24], bin_out[47:39]
    output logic [mne_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int XW = mne_pkg::FRAME_W + 1;

    logic [mne_pkg::MAG_W-1:0]   s_mag;
    logic [mne_pkg::BIN_W-1:0]   s_bin;
    logic [mne_pkg::FRAME_W-1:0] s_frame;
    logic                        s_in_range;
    logic                        hazard;
    logic                        accept;

    logic [XW-1:0]                            frame_inc;
    logic [mne_pkg::FRAME_W-1:0]              half;
    logic [mne_pkg::FRAME_W+mne_pkg::RECIP_W-1:0] recip_prod;

    logic                        v1_reg, v1_next;
    logic                        v2_reg, v2_next;
    logic                        v3_reg, v3_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        go1, go2, go3, rdy1, rdy2, rdy3;

    logic [mne_pkg::MAG_W-1:0]   mag1_reg;
    logic [mne_pkg::BIN_W-1:0]   bin1_reg;
    logic [mne_pkg::FRAME_W-1:0] frame1_reg;
    logic                        inr1_reg;
    logic                        vld1_reg;
    logic [mne_pkg::QUOT_W-1:0]  quot1_reg;
    logic [mne_pkg::FRAME_W-1:0] half1_reg;
    logic                        even1_reg;
    mne_pkg::bin_state_t         rd_reg;

    mne_pkg::bin_state_t         cur_state;
    logic [mne_pkg::FRAME_W:0]   quot_x25;
    logic                        rearm;
    mne_pkg::bin_update_t        upd;

    logic [mne_pkg::BIN_W-1:0]   bin2_reg;
    logic                        inr2_reg;
    mne_pkg::bin_update_t        upd2_reg;

    logic [mne_pkg::BIN_W-1:0]   bin3_reg;
    logic                        inr3_reg;
    mne_pkg::bin_update_t        upd3_reg;
    logic signed [mne_pkg::PROD_W-1:0] prod3_reg;

    logic signed [mne_pkg::PROD_W-1:0] total;
    logic [mne_pkg::MAG_W-1:0]   noise_new;
    logic                        wr_en;
    mne_pkg::bin_state_t         wr_word;

    logic [mne_pkg::MAG_W-1:0]   m_noise_reg;
    logic [mne_pkg::PROB_W-1:0]  m_prob_reg;
    logic [mne_pkg::BIN_W-1:0]   m_bin_reg;

    mne_pkg::bin_state_t         mem [mne_pkg::NUM_BINS];
    logic [mne_pkg::NUM_BINS-1:0] valid_reg, valid_next;

    assign s_mag      = s_tdata[mne_pkg::MAG_W-1:0];
    assign s_bin      = s_tdata[mne_pkg::MAG_W +: mne_pkg::BIN_W];
    assign s_frame    = s_tdata[mne_pkg::MAG_W+mne_pkg::BIN_W +: mne_pkg::FRAME_W];
    assign s_in_range = s_bin < mne_pkg::BIN_W'(mne_pkg::NUM_BINS);

    assign hazard = s_in_range &&
                    ((v1_reg && inr1_reg && bin1_reg == s_bin) ||
                     (v2_reg && inr2_reg && bin2_reg == s_bin) ||
                     (v3_reg && inr3_reg && bin3_reg == s_bin));

    assign go3  = v3_reg && (!m_tvalid_reg || m_tready);
    assign rdy3 = !v3_reg || go3;
    assign go2  = v2_reg && rdy3;
    assign rdy2 = !v2_reg || go2;
    assign go1  = v1_reg && rdy2;
    assign rdy1 = !v1_reg || go1;

    assign s_tready = rdy1 && !hazard;
    assign accept   = s_tvalid && s_tready;

    assign frame_inc  = {1'b0, s_frame} + XW'(1);
    assign half       = frame_inc[XW-1:1];
    assign recip_prod = {{mne_pkg::RECIP_W{1'b0}}, half}
                      * {{mne_pkg::FRAME_W{1'b0}}, mne_pkg::RECIP_W'(mne_pkg::RECIP_MULT)};

    always_comb begin
        v1_next       = accept ? 1'b1 : (go1 ? 1'b0 : v1_reg);
        v2_next       = go1 ? 1'b1 : (go2 ? 1'b0 : v2_reg);
        v3_next       = go2 ? 1'b1 : (go3 ? 1'b0 : v3_reg);
        m_tvalid_next = go3 ? 1'b1 : ((m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg);
        valid_next    = valid_reg;
        if (wr_en) begin
            valid_next[bin3_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
        end else begin
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            v3_reg       <= v3_next;
            m_tvalid_reg <= m_tvalid_next;
            valid_reg    <= valid_next;
        end
    end

    // state memory: read at acceptance, write back at the last stage
    always_ff @(posedge aclk) begin
        if (accept && s_in_range) begin
            rd_reg <= mem[s_bin];
        end
        if (wr_en) begin
            mem[bin3_reg] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mag1_reg   <= s_mag;
            bin1_reg   <= s_bin;
            frame1_reg <= s_frame;
            inr1_reg   <= s_in_range;
            vld1_reg   <= s_in_range && valid_reg[s_bin];
            quot1_reg  <= recip_prod[mne_pkg::RECIP_SHIFT +: mne_pkg::QUOT_W];
            half1_reg  <= half;
            even1_reg  <= !frame_inc[0];
        end
    end

    always_comb begin
        if (frame1_reg == '0) begin
            cur_state.level    = mag1_reg;
            cur_state.win_min  = mag1_reg;
            cur_state.run_min  = mag1_reg;
            cur_state.presence = '0;
            cur_state.noise    = mag1_reg;
        end else if (!vld1_reg) begin
            cur_state = '0;
        end else begin
            cur_state = rd_reg;
        end
        quot_x25 = {quot1_reg, 4'b0000} + {1'b0, quot1_reg, 3'b000}
                 + (mne_pkg::FRAME_W+1)'(quot1_reg);
        rearm = (frame1_reg < mne_pkg::FRAME_W'(mne_pkg::FAST_FRAMES)) ||
                (even1_reg && {1'b0, half1_reg} == quot_x25);
    end

    mne_bin_update u_update (
        .state_i   (cur_state),
        .magnitude (mag1_reg),
        .rearm     (rearm),
        .upd_o     (upd)
    );

    always_ff @(posedge aclk) begin
        if (go1) begin
            bin2_reg <= bin1_reg;
            inr2_reg <= inr1_reg;
            upd2_reg <= upd;
        end
        if (go2) begin
            bin3_reg  <= bin2_reg;
            inr3_reg  <= inr2_reg;
            upd3_reg  <= upd2_reg;
            prod3_reg <= mne_pkg::PROD_W'($signed(upd2_reg.diff))
                       * mne_pkg::PROD_W'($signed({1'b0, upd2_reg.presence}));
        end
    end

    always_comb begin
        total     = $signed({3'b000, upd3_reg.mix, {mne_pkg::FRAC_BITS{1'b0}}}) + prod3_reg;
        noise_new = total[mne_pkg::FRAC_BITS +: mne_pkg::MAG_W];
        wr_en     = go3 && inr3_reg;
        wr_word.level    = upd3_reg.level;
        wr_word.win_min  = upd3_reg.win_min;
        wr_word.run_min  = upd3_reg.run_min;
        wr_word.presence = upd3_reg.presence;
        wr_word.noise    = noise_new;
    end

    always_ff @(posedge aclk) begin
        if (go3) begin
            m_bin_reg   <= bin3_reg;
            m_noise_reg <= inr3_reg ? noise_new : '0;
            m_prob_reg  <= inr3_reg ? upd3_reg.presence : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_bin_reg, m_prob_reg, m_noise_reg};

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_in_range) |-> !(wr_en && bin3_reg == s_bin))
        else $error("read and write-back of the same bin in one cycle");

    a_prob_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_prob_reg <= mne_pkg::PROB_W'(mne_pkg::ONE_Q14)))
        else $error("presence above one");

    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_bin_reg >= mne_pkg::BIN_W'(mne_pkg::NUM_BINS))
        |-> (m_noise_reg == '0 && m_prob_reg == '0))
        else $error("out-of-range bin with nonzero result");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted item lost at first stage");

endmodule

// ===== test/mcra_noise_estimator_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mcra_noise_estimator_unit_tb
// Self-checking bench for the per-bin MCRA noise tracker. A directed burst
// covers field extremes, bin init, fast and periodic minimum re-arm, frame
// wrap, untouched and out-of-range bins. Random frame sweeps over small bin
// sets follow, with speech bursts and stray items mixed in. A built-in
// tracker of all per-bin state predicts each result, and results are
// compared in order under four flow phases: free, sender gaps, receiver
// stalls, and both.
// ============================================================================
module mcra_noise_estimator_unit_tb;
    import mne_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [BIN_W-1:0]   bin;
        logic [MAG_W-1:0]   magnitude;
    } spectral_item_t;

    typedef struct packed {
        logic [BIN_W-1:0]  bin_out;
        logic [PROB_W-1:0] presence_prob;
        logic [MAG_W-1:0]  noise_estimate;
    } noise_result_t;

    typedef enum {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_mode_t;

    localparam int BIN_MAX_CODE   = (1 << BIN_W) - 1;
    localparam int FRAME_MAX_CODE = (1 << FRAME_W) - 1;
    localparam int MAG_MAX_CODE   = (1 << MAG_W) - 1;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    spectral_item_t pending_items[$];
    noise_result_t  expected_results[$];
    flow_mode_t     flow_mode = FLOW_FREE;
    int             mismatches = 0;
    noise_result_t  result_got;
    noise_result_t  result_want;

    logic [MAG_W-1:0]  level_mem    [NUM_BINS];
    logic [MAG_W-1:0]  win_min_mem  [NUM_BINS];
    logic [MAG_W-1:0]  run_min_mem  [NUM_BINS];
    logic [PROB_W-1:0] presence_mem [NUM_BINS];
    logic [MAG_W-1:0]  noise_mem    [NUM_BINS];

    mcra_noise_estimator_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [MAG_W-1:0] min_mag(input logic [MAG_W-1:0] a,
                                                 input logic [MAG_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Advance one bin's tracker state and return the noise update it yields.
    function automatic noise_result_t track_noise_bin(input spectral_item_t it);
        noise_result_t     r;
        logic [MAG_W-1:0]  y, s, smin, stmp, n;
        logic [PROB_W-1:0] pr, p;
        logic [31:0]       level_sum;
        logic [63:0]       thr, mix;
        int unsigned       b;
        r.bin_out        = it.bin;
        r.presence_prob  = '0;
        r.noise_estimate = '0;
        if (int'(it.bin) >= NUM_BINS) begin
            return r;
        end
        b = 32'(it.bin);
        y = it.magnitude;
        if (it.frame == '0) begin
            level_mem[b]    = y;
            win_min_mem[b]  = y;
            run_min_mem[b]  = y;
            noise_mem[b]    = y;
            presence_mem[b] = '0;
        end
        s    = level_mem[b];
        smin = win_min_mem[b];
        stmp = run_min_mem[b];
        pr   = presence_mem[b];
        n    = noise_mem[b];

        if (int'(it.frame) < FAST_FRAMES || (32'(it.frame) + 1) % REARM_PERIOD == 0) begin
            smin = min_mag(stmp, s);
            stmp = s;
        end

        level_sum = 32'(s >> 1) + 32'(s >> 2) + 32'(s >> 4) + 32'(y >> 3) + 32'(y >> 4);
        s    = level_sum[MAG_W-1:0];
        smin = min_mag(smin, s);
        stmp = min_mag(stmp, s);

        thr = 64'(smin >> 2) + (64'(smin) << 1);
        p   = (64'(s) > thr) ? PROB_W'(ONE_Q14) : '0;
        pr  = (pr >> 2) + (p >> 1) + (p >> 2);
        if (int'(pr) > ONE_Q14) begin
            pr = PROB_W'(ONE_Q14);
        end

        mix = 64'(n >> 1) + 64'(n >> 2) + 64'(n >> 3) + 64'(n >> 4) + 64'(y >> 4);
        mix = mix * 64'(ONE_Q14 - int'(pr)) + 64'(n) * 64'(pr);
        n   = mix[FRAC_BITS +: MAG_W];

        level_mem[b]    = s;
        win_min_mem[b]  = smin;
        run_min_mem[b]  = stmp;
        presence_mem[b] = pr;
        noise_mem[b]    = n;

        r.presence_prob  = pr;
        r.noise_estimate = n;
        return r;
    endfunction

    function automatic bit hold_off(input bit at_sink);
        case (flow_mode)
            FLOW_SRC_GAPS:    return !at_sink && $urandom_range(0, 99) < 83;
            FLOW_SINK_STALLS: return at_sink && $urandom_range(0, 99) < 83;
            FLOW_BOTH:        return $urandom_range(0, 99) < 26;
            default:          return 1'b0;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(
                    track_noise_bin(spectral_item_t'(s_tdata[$bits(spectral_item_t)-1:0])));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && !hold_off(1'b0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'(pending_items.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off(1'b1);
            if (m_tvalid && m_tready) begin
                result_got = noise_result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual bin %0d noise %0d prob %0d",
                             $time, result_got.bin_out, result_got.noise_estimate,
                             result_got.presence_prob);
                    mismatches++;
                end else begin
                    result_want = expected_results.pop_front();
                    if (result_got.noise_estimate !== result_want.noise_estimate) begin
                        $display("%0t: noise_estimate expected %0d actual %0d (bin %0d)", $time,
                                 result_want.noise_estimate, result_got.noise_estimate,
                                 result_want.bin_out);
                        mismatches++;
                    end
                    if (result_got.presence_prob !== result_want.presence_prob) begin
                        $display("%0t: presence_prob expected %0d actual %0d (bin %0d)", $time,
                                 result_want.presence_prob, result_got.presence_prob,
                                 result_want.bin_out);
                        mismatches++;
                    end
                    if (result_got.bin_out !== result_want.bin_out) begin
                        $display("%0t: bin_out expected %0d actual %0d", $time,
                                 result_want.bin_out, result_got.bin_out);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic add_item(input logic [MAG_W-1:0] mag, input logic [BIN_W-1:0] bin_idx,
                            input logic [FRAME_W-1:0] frame_no);
        pending_items.push_back('{frame: frame_no, bin: bin_idx, magnitude: mag});
    endtask

    task automatic add_directed_items();
        add_item(MAG_W'(MAG_MAX_CODE), '0, '0);
        add_item(MAG_W'(MAG_MAX_CODE), '0, FRAME_W'(1));
        add_item('0, '0, FRAME_W'(2));
        add_item('0, BIN_W'(NUM_BINS - 1), '0);
        add_item(MAG_W'(MAG_MAX_CODE), BIN_W'(NUM_BINS - 1), FRAME_W'(1));
        add_item(MAG_W'(MAG_MAX_CODE), BIN_W'(NUM_BINS - 1), FRAME_W'(2));
        add_item(24'h123456, BIN_W'(NUM_BINS), '0);
        add_item(MAG_W'(MAG_MAX_CODE), BIN_W'(BIN_MAX_CODE), FRAME_W'(FRAME_MAX_CODE));
        add_item(MAG_W'(1000), BIN_W'(100), FRAME_W'(5));
        add_item(MAG_W'(50), BIN_W'(1), '0);
        add_item(MAG_W'(50), BIN_W'(1), FRAME_W'(FAST_FRAMES - 1));
        add_item(MAG_W'(50), BIN_W'(1), FRAME_W'(FAST_FRAMES));
        add_item(MAG_W'(4000), BIN_W'(1), FRAME_W'(REARM_PERIOD - 2));
        add_item(MAG_W'(4000), BIN_W'(1), FRAME_W'(REARM_PERIOD - 1));
        add_item(MAG_W'(4000), BIN_W'(1), FRAME_W'(REARM_PERIOD));
        add_item(MAG_W'(50), BIN_W'(2), FRAME_W'(FRAME_MAX_CODE));
        add_item(MAG_W'(50), BIN_W'(2), FRAME_W'(FRAME_MAX_CODE - 26));
        add_item('0, BIN_W'(3), '0);
        add_item(24'hAAAAAA, BIN_W'(3), 20'h55555);
        add_item(24'h555555, BIN_W'(3), 20'hAAAAA);
        add_item(MAG_W'(MAG_MAX_CODE), BIN_W'(NUM_BINS - 2), '0);
        add_item(MAG_W'(1), BIN_W'(NUM_BINS - 2), FRAME_W'(1));
        add_item(24'h800000, BIN_W'(170), '0);
        add_item(24'h000001, BIN_W'(85), 20'h80000);
    endtask

    // Sweep frames over a small bin set: an opening run through the fast
    // frames and the first re-arm, then a short tail from another base frame.
    task automatic add_frame_sweeps(input int unsigned n_items);
        int unsigned        added, n_bins, run_len, tail_len, rot, slot, f_idx, scaled;
        logic [FRAME_W-1:0] frame_no, tail_base;
        logic [BIN_W-1:0]   sweep_bins [8];
        logic [MAG_W-1:0]   floor_mag  [8];
        bit                 talking;
        added = 0;
        while (added < n_items) begin
            n_bins = $urandom_range(3, 8);
            for (int i = 0; i < n_bins; i++) begin
                sweep_bins[i] = BIN_W'($urandom_range(0, NUM_BINS - 1));
                floor_mag[i]  = MAG_W'($urandom_range(0, 1 << $urandom_range(2, 20)));
            end
            run_len  = $urandom_range(52, 64);
            tail_len = $urandom_range(4, 12);
            case ($urandom_range(0, 2))
                0:       tail_base = FRAME_W'(REARM_PERIOD * $urandom_range(1, 20) - 3);
                1:       tail_base = FRAME_W'(FRAME_MAX_CODE - $urandom_range(0, 5));
                default: tail_base = FRAME_W'($urandom);
            endcase
            talking = 1'b0;
            for (f_idx = 0; f_idx < run_len + tail_len && added < n_items; f_idx++) begin
                frame_no = (f_idx < run_len) ? FRAME_W'(f_idx)
                                             : FRAME_W'(32'(tail_base) + f_idx - run_len);
                if ($urandom_range(0, 99) < 15) begin
                    talking = !talking;
                end
                rot = $urandom_range(0, n_bins - 1);
                for (int k = 0; k < n_bins; k++) begin
                    slot   = (k + rot) % n_bins;
                    scaled = floor_mag[slot] + $urandom_range(0, floor_mag[slot] / 2 + 1);
                    if (talking) begin
                        scaled = scaled * $urandom_range(3, 16);
                    end
                    if ($urandom_range(0, 99) < 3) begin
                        scaled = $urandom_range(0, MAG_MAX_CODE);
                    end
                    if (scaled > MAG_MAX_CODE) begin
                        scaled = MAG_MAX_CODE;
                    end
                    add_item(MAG_W'(scaled), sweep_bins[slot], frame_no);
                    added++;
                    if ($urandom_range(0, 99) < 12) begin
                        add_item(MAG_W'($urandom), BIN_W'($urandom_range(0, BIN_MAX_CODE)),
                                 FRAME_W'($urandom));
                        added++;
                    end
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_BINS; i++) begin
            level_mem[i]    = '0;
            win_min_mem[i]  = '0;
            run_min_mem[i]  = '0;
            presence_mem[i] = '0;
            noise_mem[i]    = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        flow_mode = FLOW_FREE;
        add_directed_items();
        add_frame_sweeps(390);
        wait_drained();

        flow_mode = FLOW_SRC_GAPS;
        add_frame_sweeps(390);
        wait_drained();

        flow_mode = FLOW_SINK_STALLS;
        add_frame_sweeps(390);
        wait_drained();

        flow_mode = FLOW_BOTH;
        add_frame_sweeps(390);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
